/* rtl/txu_pkg.sv */
// txu_pkg: shared types and constants for the toy isa execute unit
// payload structs, opcode and state enums, controller command and status structs
// no dependencies
package txu_pkg;

    localparam int REG_COUNT_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_IDX_W    = 4;
    localparam int IMM_W          = 8;
    localparam int LINE_COUNT_W   = 9;
    localparam int STORE_W        = 32;
    localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST = 9'd256;

    typedef enum logic [3:0] {
        OP_SET   = 4'd0,
        OP_JUMP  = 4'd1,
        OP_STORE = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MOD   = 4'd5,
        OP_POW   = 4'd6,
        OP_JEQ   = 4'd7,
        OP_JLT   = 4'd8
    } t_kind;

    typedef struct packed {
        logic [3:0]             kind;
        logic [FIELD_IDX_W-1:0] reg_a;
        logic [FIELD_IDX_W-1:0] reg_b;
        logic [FIELD_IDX_W-1:0] reg_c;
        logic [IMM_W-1:0]       immediate;
    } t_in;

    typedef struct packed {
        logic                      status;
        logic                      jump_taken;
        logic [IMM_W-1:0]          jump_line;
        logic                      store_valid;
        logic signed [STORE_W-1:0] store_value;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DIV_WR,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_WR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_write;
        logic pow_start;
        logic mul_start;
        logic pow_step;
        logic pow_write;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic op_mod;
        logic op_pow;
        logic div_last;
        logic pow_zero;
        logic mul_done;
        logic out_free;
    } t_ctl_sts;

endpackage

/* rtl/txu_mul.sv */
// txu_mul: truncating multiplier, consumes the second operand in chunks
// one chunk per cycle, low DATA_WIDTH bits of the product, done pulse at the end
// depends on nothing outside this file
module txu_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_x,
    input  logic [DATA_WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_p
);
    localparam int CW    = (DATA_WIDTH <= 32) ? DATA_WIDTH : 16;
    localparam int STEPS = (DATA_WIDTH + CW - 1) / CW;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DATA_WIDTH-1:0]    r_x;
    logic [DATA_WIDTH-1:0]    r_y;
    logic [DATA_WIDTH-1:0]    r_p;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [DATA_WIDTH+CW-1:0] pp;

    assign pp = {{CW{1'b0}}, r_x} * {{DATA_WIDTH{1'b0}}, r_y[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_p   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_p   <= r_p + pp[DATA_WIDTH-1:0];
            r_x   <= r_x << CW;
            r_y   <= r_y >> CW;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

/* rtl/txu_datapath.sv */
// txu_datapath: register file, instruction registers, divider, power loop, output beat
// follows commands from txu_ctrl and reports status back
// depends on txu_pkg and txu_mul
module txu_datapath #(
    parameter int REG_COUNT  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  txu_pkg::t_in                          i_in,
    input  logic                                  i_cfg_wr_en,
    input  logic [txu_pkg::LINE_COUNT_W-1:0]      i_cfg_wr_data,
    input  txu_pkg::t_ctl_cmd                     i_cmd,
    output txu_pkg::t_ctl_sts                     o_sts,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output txu_pkg::t_out                         o_out
);
    import txu_pkg::*;

    localparam int IDX_W   = $clog2(REG_COUNT);
    localparam int DCNT_W  = $clog2(DATA_WIDTH);
    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

    function automatic logic [IDX_W-1:0] f_idx(input logic [FIELD_IDX_W-1:0] i);
        int v;
        v = int'(i);
        for (int k = 0; k < 4; k++) begin
            if (v >= REG_COUNT) begin
                v = v - REG_COUNT;
            end
        end
        return IDX_W'(v);
    endfunction

    // register file
    logic [DATA_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_vld;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]      rd_ia;
    logic [IDX_W-1:0]      rd_ib;

    // instruction and operands
    logic [3:0]              r_kind;
    logic [FIELD_IDX_W-1:0]  r_ra;
    logic [IDX_W-1:0]        r_ia;
    logic [IDX_W-1:0]        r_ic;
    logic [IMM_W-1:0]        r_imm;
    logic [DATA_WIDTH-1:0]   r_rd_a;
    logic [DATA_WIDTH-1:0]   r_rd_b;
    logic                    r_halted;
    logic [LINE_COUNT_W-1:0] r_line_count;
    t_out                    r_res;
    t_out                    n_res;

    // divider
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_den;
    logic                  r_neg;
    logic [DCNT_W-1:0]     r_dcnt;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH-1:0] div_res;

    // power
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_sq;
    logic [DATA_WIDTH-1:0] r_ex;
    logic [DATA_WIDTH-1:0] p_acc;
    logic [DATA_WIDTH-1:0] p_sq;
    logic                  done_acc;
    logic                  done_sq;

    // output beat
    logic r_out_valid;
    t_out r_out;

    // exec decode
    logic                  bad_idx;
    logic                  fail;
    logic                  wr_ex;
    logic [IDX_W-1:0]      wr_ex_idx;
    logic [DATA_WIDTH-1:0] wr_ex_data;
    logic                  cond;

    assign rd_ia = f_idx(i_in.reg_a);
    assign rd_ib = f_idx(i_in.reg_b);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.load) begin
            r_rd_a <= r_vld[rd_ia] ? r_mem[rd_ia] : ((rd_ia == IDX_W'(1)) ? ONE : '0);
            r_rd_b <= r_vld[rd_ib] ? r_mem[rd_ib] : ((rd_ib == IDX_W'(1)) ? ONE : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_halted     <= 1'b0;
            r_line_count <= LINE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.exec && fail) begin
                r_halted <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_line_count <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in.kind;
            r_ra   <= i_in.reg_a;
            r_ia   <= rd_ia;
            r_ic   <= f_idx(i_in.reg_c);
            r_imm  <= i_in.immediate;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // instruction decode for the exec cycle
    always_comb begin
        bad_idx    = (r_ra <= FIELD_IDX_W'(1)) || (int'(r_ra) > REG_COUNT - 1);
        cond       = (r_kind == OP_JEQ) ? (r_rd_a == r_rd_b)
                                        : ($signed(r_rd_a) < $signed(r_rd_b));
        n_res      = '0;
        fail       = 1'b0;
        wr_ex      = 1'b0;
        wr_ex_idx  = r_ic;
        wr_ex_data = '0;
        if (r_halted) begin
            n_res.status = 1'b1;
        end else begin
            unique case (r_kind) inside
                OP_SET: begin
                    if (bad_idx) begin
                        fail = 1'b1;
                    end else begin
                        wr_ex      = 1'b1;
                        wr_ex_idx  = r_ia;
                        wr_ex_data = DATA_WIDTH'(r_imm);
                    end
                end
                OP_JUMP: begin
                    if ({1'b0, r_imm} > r_line_count) begin
                        fail = 1'b1;
                    end else begin
                        n_res.jump_taken = 1'b1;
                        n_res.jump_line  = r_imm;
                    end
                end
                OP_STORE: begin
                    if (bad_idx) begin
                        fail = 1'b1;
                    end else begin
                        n_res.store_valid = 1'b1;
                        n_res.store_value = STORE_W'(r_rd_a);
                    end
                end
                OP_ADD: begin
                    wr_ex      = 1'b1;
                    wr_ex_data = r_rd_a + r_rd_b;
                end
                OP_SUB: begin
                    wr_ex      = 1'b1;
                    wr_ex_data = r_rd_a - r_rd_b;
                end
                OP_MOD, OP_POW: begin
                end
                OP_JEQ, OP_JLT: begin
                    if (cond && ({1'b0, r_imm} <= r_line_count)) begin
                        n_res.jump_taken = 1'b1;
                        n_res.jump_line  = r_imm;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
            if (fail) begin
                n_res        = '0;
                n_res.status = 1'b1;
            end
        end
    end

    // restoring division on magnitudes
    assign rem_sh  = {r_rem, r_q[DATA_WIDTH-1]};
    assign div_res = (r_den == '0) ? '0 : (r_neg ? ('0 - r_rem) : r_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_q    <= r_rd_a[DATA_WIDTH-1] ? ('0 - r_rd_a) : r_rd_a;
            r_den  <= r_rd_b[DATA_WIDTH-1] ? ('0 - r_rd_b) : r_rd_b;
            r_neg  <= r_rd_a[DATA_WIDTH-1];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= DATA_WIDTH'(rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= rem_sh[DATA_WIDTH-1:0];
            end
            r_q    <= r_q << 1;
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // square and multiply, exponent bits from the bottom
    txu_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (r_acc),
        .i_y     (r_sq),
        .o_done  (done_acc),
        .o_p     (p_acc)
    );

    txu_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (r_sq),
        .i_y     (r_sq),
        .o_done  (done_sq),
        .o_p     (p_sq)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_start) begin
            r_sq <= r_rd_a;
            if (r_rd_b[DATA_WIDTH-1]) begin
                // negative exponent: only bases of plus or minus one survive
                r_ex <= '0;
                if (r_rd_a == ONE) begin
                    r_acc <= ONE;
                end else if (r_rd_a == '1) begin
                    r_acc <= r_rd_b[0] ? '1 : ONE;
                end else begin
                    r_acc <= '0;
                end
            end else begin
                r_ex  <= r_rd_b;
                r_acc <= ONE;
            end
        end else if (i_cmd.pow_step) begin
            if (r_ex[0]) begin
                r_acc <= p_acc;
            end
            r_sq <= p_sq;
            r_ex <= r_ex >> 1;
        end
    end

    // register file write port
    always_comb begin
        wr_en   = (i_cmd.exec && wr_ex) || i_cmd.div_write || i_cmd.pow_write;
        wr_idx  = i_cmd.exec ? wr_ex_idx : r_ic;
        wr_data = i_cmd.div_write ? div_res : (i_cmd.pow_write ? r_acc : wr_ex_data);
    end

    always_comb begin
        o_sts          = '0;
        o_sts.op_mod   = !r_halted && (r_kind == OP_MOD);
        o_sts.op_pow   = !r_halted && (r_kind == OP_POW);
        o_sts.div_last = (r_dcnt == DCNT_W'(DATA_WIDTH - 1));
        o_sts.pow_zero = (r_ex == '0);
        o_sts.mul_done = done_acc && done_sq;
        o_sts.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

/* rtl/txu_ctrl.sv */
// txu_ctrl: sequencing state machine for the execute unit
// drives datapath commands, reads datapath status
// depends on txu_pkg
module txu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output txu_pkg::t_ctl_cmd o_cmd,
    input  txu_pkg::t_ctl_sts i_sts
);
    import txu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.op_mod) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else if (i_sts.op_pow) begin
                    o_cmd.pow_start = 1'b1;
                    n_state         = ST_POW_CHK;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DIV_WR;
                end
            end
            ST_DIV_WR: begin
                o_cmd.div_write = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_POW_CHK: begin
                if (i_sts.pow_zero) begin
                    n_state = ST_POW_WR;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = ST_POW_MUL;
                end
            end
            ST_POW_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.pow_step = 1'b1;
                    n_state        = ST_POW_CHK;
                end
            end
            ST_POW_WR: begin
                o_cmd.pow_write = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/toy_isa_execute_unit.sv */
// toy_isa_execute_unit: top level, executes one decoded instruction per beat
// depends on txu_pkg, txu_ctrl, txu_datapath, txu_mul
//
// input channel: i_valid / o_stall with payload i_in; a beat is taken when
// i_valid is high and o_stall is low. output channel: o_valid / i_stall with
// payload o_out, one result beat per input beat, in order.
// line_count is written through i_cfg_wr_en / i_cfg_wr_data by the user only
// while idle; the block itself does not enforce it. one instruction is in
// flight at a time; o_stall is low only between instructions. mod takes one
// quotient bit per cycle in the divider; pow steps through the bits of the
// exponent (none if negative) through the shared square/multiply pair.
// the output register holds one result, so the next beat is accepted while
// a result waits; a stalled receiver only holds back the following result.
// reset clears the register file (r1 reads as one), the halt flag, the
// output valid and sets line_count to 256; no clearing pass is needed.
module toy_isa_execute_unit #(
    parameter int REG_COUNT  = txu_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = txu_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  txu_pkg::t_in                     i_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output txu_pkg::t_out                    o_out,
    input  logic                             i_cfg_wr_en,
    input  logic [txu_pkg::LINE_COUNT_W-1:0] i_cfg_wr_data
);
    import txu_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    txu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    txu_datapath #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out         (o_out)
    );

endmodule

/* test/txu_checker.sv */
`timescale 1ns / 1ps
// txu_checker: watches both channels and the config port of the execute unit,
// predicts every result beat from its own register file copy and compares them
// depends on txu_pkg
module txu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  txu_pkg::t_in                     i_in_beat,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  txu_pkg::t_out                    i_out_beat,
    input  logic                             i_cfg_wr_en,
    input  logic [txu_pkg::LINE_COUNT_W-1:0] i_cfg_wr_data,
    output int                               o_mismatches,
    output int                               o_pending
);
    import txu_pkg::*;

    localparam int W              = DATA_WIDTH_DEF;
    localparam int FIRST_FREE_REG = 2;

    logic [W-1:0]            regs [REG_COUNT_DEF];
    logic                    halted;
    logic [LINE_COUNT_W-1:0] line_count;
    t_out                    results_due [$];

    function automatic t_out execute_beat(input t_in ins);
        t_out         r;
        logic [W-1:0] a, b, ma, mb, rem, acc, sq;
        logic         fail;
        r = '0;
        if (halted) begin
            r.status = 1'b1;
            return r;
        end
        a    = regs[ins.reg_a];
        b    = regs[ins.reg_b];
        fail = 1'b0;
        case (ins.kind)
            OP_SET: begin
                if (ins.reg_a < FIRST_FREE_REG) fail = 1'b1;
                else regs[ins.reg_a] = W'(ins.immediate);
            end
            OP_JUMP: begin
                if (ins.immediate > line_count) begin
                    fail = 1'b1;
                end else begin
                    r.jump_taken = 1'b1;
                    r.jump_line  = ins.immediate;
                end
            end
            OP_STORE: begin
                if (ins.reg_a < FIRST_FREE_REG) begin
                    fail = 1'b1;
                end else begin
                    r.store_valid = 1'b1;
                    r.store_value = regs[ins.reg_a];
                end
            end
            OP_ADD: regs[ins.reg_c] = a + b;
            OP_SUB: regs[ins.reg_c] = a - b;
            OP_MOD: begin
                // truncating, sign follows the dividend
                ma = a[W-1] ? -a : a;
                mb = b[W-1] ? -b : b;
                if (mb == '0) begin
                    regs[ins.reg_c] = '0;
                end else begin
                    rem = ma % mb;
                    regs[ins.reg_c] = a[W-1] ? -rem : rem;
                end
            end
            OP_POW: begin
                if (b[W-1]) begin
                    if (a == W'(1)) acc = W'(1);
                    else if (a == '1) acc = b[0] ? '1 : W'(1);
                    else acc = '0;
                end else begin
                    acc = W'(1);
                    sq  = a;
                    for (int i = 0; i < W; i++) begin
                        if (b[i]) acc = acc * sq;
                        sq = sq * sq;
                    end
                end
                regs[ins.reg_c] = acc;
            end
            OP_JEQ, OP_JLT: begin
                if (((ins.kind == OP_JEQ) ? (a == b) : ($signed(a) < $signed(b)))
                        && ins.immediate <= line_count) begin
                    r.jump_taken = 1'b1;
                    r.jump_line  = ins.immediate;
                end
            end
            default: fail = 1'b1;
        endcase
        if (fail) begin
            halted   = 1'b1;
            r        = '0;
            r.status = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [W-1:0] want,
                               input logic [W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (regs[k]) regs[k] = '0;
            regs[1]      = W'(1);
            halted       = 1'b0;
            line_count   = LINE_COUNT_RST;
            o_mismatches = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with no prediction pending: 0x%0h", i_out_beat);
                    o_mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", W'(want.status), W'(i_out_beat.status));
                    check_field("jump_taken", W'(want.jump_taken), W'(i_out_beat.jump_taken));
                    check_field("jump_line", W'(want.jump_line), W'(i_out_beat.jump_line));
                    check_field("store_valid", W'(want.store_valid),
                                W'(i_out_beat.store_valid));
                    check_field("store_value", W'(want.store_value),
                                W'(i_out_beat.store_value));
                end
            end
            if (i_in_valid && !i_in_stall) results_due.push_back(execute_beat(i_in_beat));
            if (i_cfg_wr_en) line_count = i_cfg_wr_data;
        end
        o_pending = results_due.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives directed and random instruction beats and line_count writes
// into the execute unit with random idles, a steady stretch and a long hold-off
// depends on txu_pkg, toy_isa_execute_unit, txu_checker
module testbench;
    import txu_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 23;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 150;
    localparam int QUIET_LIMIT    = 2000;
    localparam int FIRST_FREE_REG = 2;
    localparam int LAST_REG       = REG_COUNT_DEF - 1;
    localparam int UNKNOWN_LO     = int'(OP_JLT) + 1;
    localparam int UNKNOWN_HI     = 15;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    t_in                     i_in;
    logic                    o_valid;
    logic                    i_stall;
    t_out                    o_out;
    logic                    i_cfg_wr_en;
    logic [LINE_COUNT_W-1:0] i_cfg_wr_data;
    int                      mismatches;
    int                      pending;
    int                      quiet_cycles = 0;
    int unsigned             lc_now;
    bit                      steady;
    bit                      hold_req;

    toy_isa_execute_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in          (i_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    txu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_beat     (i_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_beat    (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic t_in instr(input t_kind kind, input int ra, input int rb,
                                  input int rc, input int imm);
        t_in b;
        b.kind      = kind;
        b.reg_a     = FIELD_IDX_W'(ra);
        b.reg_b     = FIELD_IDX_W'(rb);
        b.reg_c     = FIELD_IDX_W'(rc);
        b.immediate = IMM_W'(imm);
        return b;
    endfunction

    function automatic t_in random_instr(input int unsigned lc);
        t_in         b;
        int unsigned pick;
        b = instr(OP_ADD, $urandom_range(0, LAST_REG), $urandom_range(0, LAST_REG),
                  ($urandom_range(0, 99) < 85) ? $urandom_range(FIRST_FREE_REG, LAST_REG)
                                               : $urandom_range(0, FIRST_FREE_REG - 1),
                  $urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            b.kind  = OP_SET;
            b.reg_a = FIELD_IDX_W'($urandom_range(FIRST_FREE_REG, LAST_REG));
        end else if (pick < 35) begin
            b.kind  = OP_STORE;
            b.reg_a = FIELD_IDX_W'($urandom_range(FIRST_FREE_REG, LAST_REG));
        end else if (pick < 47) begin
            b.kind = OP_ADD;
        end else if (pick < 59) begin
            b.kind = OP_SUB;
        end else if (pick < 69) begin
            b.kind = OP_MOD;
        end else if (pick < 77) begin
            b.kind = OP_POW;
        end else if (pick < 83) begin
            b.kind      = OP_JUMP;
            b.immediate = IMM_W'($urandom_range(0, (lc > 255) ? 255 : lc));
        end else begin
            b.kind = (pick < 91) ? OP_JEQ : OP_JLT;
            if ($urandom_range(0, 1) == 0) b.reg_b = b.reg_a;
        end
        return b;
    endfunction

    // one of the halting cases, chosen at random
    function automatic t_in halting_instr(input int unsigned lc);
        t_in b;
        b = random_instr(lc);
        case ($urandom_range(0, 3))
            0: begin
                b.kind  = OP_SET;
                b.reg_a = FIELD_IDX_W'($urandom_range(0, FIRST_FREE_REG - 1));
            end
            1: begin
                b.kind  = OP_STORE;
                b.reg_a = FIELD_IDX_W'($urandom_range(0, FIRST_FREE_REG - 1));
            end
            2: begin
                b.kind      = OP_JUMP;
                b.immediate = IMM_W'($urandom_range(lc + 1, 255));
            end
            default: b.kind = 4'($urandom_range(UNKNOWN_LO, UNKNOWN_HI));
        endcase
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input t_in beat);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_beat(random_instr(lc_now));
    endtask

    task automatic write_line_count(input int unsigned value);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= LINE_COUNT_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lc_now = value;
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in          = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        lc_now        = LINE_COUNT_RST;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, every operation, arithmetic corners
        send_beat(instr(OP_SET,   2, 0, 0, 255));
        send_beat(instr(OP_SET,  15, 0, 0, 0));
        send_beat(instr(OP_SET,   3, 0, 0, 2));
        send_beat(instr(OP_STORE, 2, 0, 0, 0));
        send_beat(instr(OP_ADD,   2, 1, 4, 0));
        send_beat(instr(OP_SUB,   0, 1, 5, 0));
        send_beat(instr(OP_SET,   7, 0, 0, 31));
        send_beat(instr(OP_POW,   3, 7, 8, 0));
        send_beat(instr(OP_STORE, 8, 0, 0, 0));
        send_beat(instr(OP_SUB,   8, 1, 9, 0));
        send_beat(instr(OP_STORE, 9, 0, 0, 0));
        send_beat(instr(OP_ADD,   9, 1, 10, 0));
        send_beat(instr(OP_MOD,   5, 3, 11, 0));
        send_beat(instr(OP_MOD,   8, 5, 12, 0));
        send_beat(instr(OP_MOD,   2, 0, 12, 0));
        send_beat(instr(OP_POW,   0, 0, 13, 0));
        send_beat(instr(OP_POW,   2, 5, 13, 0));
        send_beat(instr(OP_POW,   1, 5, 13, 0));
        send_beat(instr(OP_POW,   5, 5, 14, 0));
        send_beat(instr(OP_POW,   5, 8, 15, 0));
        send_beat(instr(OP_STORE, 14, 0, 0, 0));
        send_beat(instr(OP_JUMP,  0, 0, 0, 255));
        send_beat(instr(OP_JEQ,   2, 2, 0, 200));
        send_beat(instr(OP_JEQ,   2, 3, 0, 200));
        send_beat(instr(OP_JLT,   5, 1, 0, 0));
        send_beat(instr(OP_JLT,   1, 5, 0, 0));

        run_random(150);
        steady = 1'b1;
        run_random(250);
        steady = 1'b0;

        write_line_count(1);
        send_beat(instr(OP_JUMP, 0, 0, 0, 1));
        send_beat(instr(OP_JEQ,  2, 2, 0, 2));
        run_random(330);

        write_line_count($urandom_range(2, 255));
        hold_req = 1'b1;
        run_random(350);

        write_line_count(LINE_COUNT_RST);
        run_random(300);

        write_line_count($urandom_range(1, 200));
        run_random(300);
        send_beat(halting_instr(lc_now));
        run_random(6);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* toy_isa_execute_unit.f */
rtl/txu_pkg.sv
rtl/txu_mul.sv
rtl/txu_datapath.sv
rtl/txu_ctrl.sv
rtl/toy_isa_execute_unit.sv
test/txu_checker.sv
test/testbench.sv
